### sv/rgbhsl_pkg.sv
// Package for the RGB to HSL converter: shared constants for the hue width
// and the sixteenths per sector, used by the dividing back part and the top.
// No dependencies.
package rgbhsl_pkg;
	localparam int unsigned HUE_BITS = 13;
	localparam int unsigned SIXTEENTHS_PER_SECTOR = 960;
endpackage

### sv/rgbhsl_front.sv
// Front part: accepts pixels, finds max and min, forms hue numerator and
// saturation denominator. Depends on rgbhsl_pkg.
module rgbhsl_front #(
	parameter int unsigned CB = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [CB-1:0] red,
	input  logic [CB-1:0] green,
	input  logic [CB-1:0] blue,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [CB+2:0] num,
	output logic [CB-1:0] span,
	output logic [CB:0]   den,
	output logic [CB:0]   sum,
	output logic          gray
);
	import rgbhsl_pkg::*;
	localparam logic [CB:0] FS = {1'b0, {CB{1'b1}}};
	logic [CB-1:0] hi, lo;
	logic [CB-1:0] sp;
	logic [CB:0] sm;
	logic [CB+2:0] nm, spx;
	logic valid_q;

	always_comb begin
		hi = red;
		if (green > hi) hi = green;
		if (blue > hi) hi = blue;
		lo = red;
		if (green < lo) lo = green;
		if (blue < lo) lo = blue;
		sp = hi - lo;
		sm = {1'b0, hi} + {1'b0, lo};
		spx = {3'b000, sp};
		if (red >= green && red >= blue) begin
			if (green >= blue) nm = {3'b000, green} - {3'b000, blue};
			else nm = 3'd6 * spx - ({3'b000, blue} - {3'b000, green});
		end else if (green >= blue) begin
			nm = (spx << 1) + {3'b000, blue} - {3'b000, red};
		end else begin
			nm = (spx << 2) + {3'b000, red} - {3'b000, green};
		end
	end

	assign in_ready = !valid_q || out_ready;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= 1'b0;
		else if (in_ready) valid_q <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			num  <= nm;
			span <= sp;
			sum  <= sm;
			gray <= (sp == '0);
			den  <= (sm <= FS) ? sm : ((FS << 1) - sm);
		end
	end
endmodule

### sv/rgbhsl_queue.sv
// Two-entry queue between front and back parts. Depends on nothing.
module rgbhsl_queue #(
	parameter int unsigned W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [W-1:0] in_data,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [W-1:0] out_data
);
	logic [W-1:0] mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic wr, rd;

	assign in_ready = cnt_q != 2'd2;
	assign out_valid = cnt_q != 2'd0;
	assign out_data = mem_q[rp_q];
	assign wr = in_valid && in_ready;
	assign rd = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) wp_q <= !wp_q;
			if (rd) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= in_data;
	end
endmodule

### sv/rgbhsl_back.sv
// Back part: pipelined restoring dividers for hue and saturation, one
// quotient bit per stage. Depends on rgbhsl_pkg.
module rgbhsl_back #(
	parameter int unsigned CB = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [CB+2:0]                 num,
	input  logic [CB-1:0]                 span,
	input  logic [CB:0]                   den,
	input  logic [CB:0]                   sum,
	input  logic                          gray,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [rgbhsl_pkg::HUE_BITS-1:0] hue,
	output logic [CB-1:0]                 sat,
	output logic [CB:0]                   lsum,
	output logic                          gr
);
	import rgbhsl_pkg::*;
	localparam int unsigned HN = CB + 13;
	localparam int unsigned SN = 2 * CB;
	localparam int unsigned ST = (HN > SN) ? HN : SN;
	localparam logic [CB-1:0] FS = {CB{1'b1}};

	logic [ST:0] v_s;
	logic [HN-1:0] hn_s [ST+1];
	logic [HN-1:0] hq_s [ST+1];
	logic [HN-1:0] hr_s [ST+1];
	logic [SN-1:0] sn_s [ST+1];
	logic [SN-1:0] sq_s [ST+1];
	logic [SN:0]   sr_s [ST+1];
	logic [CB-1:0] hd_s [ST+1];
	logic [CB:0]   sd_s [ST+1];
	logic [CB:0]   l_s [ST+1];
	logic          g_s [ST+1];
	logic adv;

	assign adv = !v_s[ST] || out_ready;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s <= '0;
		else if (adv) v_s <= {v_s[ST-1:0], in_valid};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hn_s[0] <= HN'(num) * HN'(SIXTEENTHS_PER_SECTOR);
			hq_s[0] <= '0;
			hr_s[0] <= '0;
			sn_s[0] <= SN'(span) * SN'(FS);
			sq_s[0] <= '0;
			sr_s[0] <= '0;
			hd_s[0] <= gray ? CB'(1) : span;
			sd_s[0] <= gray ? (CB+1)'(1) : den;
			l_s[0] <= sum;
			g_s[0] <= gray;
		end
	end

	for (genvar i = 0; i < ST; i++) begin : g_div
		logic [HN-1:0] hr, hq;
		logic [SN:0] sr;
		logic [SN-1:0] sq;
		always_comb begin
			hr = hr_s[i];
			hq = hq_s[i];
			if (i < HN) begin
				hr = {hr_s[i][HN-2:0], hn_s[i][HN-1-((i < HN) ? i : 0)]};
				hq = hq_s[i] << 1;
				if (hr >= HN'(hd_s[i])) begin
					hr = hr - HN'(hd_s[i]);
					hq[0] = 1'b1;
				end
			end
			sr = sr_s[i];
			sq = sq_s[i];
			if (i < SN) begin
				sr = {sr_s[i][SN-1:0], sn_s[i][SN-1-((i < SN) ? i : 0)]};
				sq = sq_s[i] << 1;
				if (sr >= (SN+1)'(sd_s[i])) begin
					sr = sr - (SN+1)'(sd_s[i]);
					sq[0] = 1'b1;
				end
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				hn_s[i+1] <= hn_s[i];
				hq_s[i+1] <= hq;
				hr_s[i+1] <= hr;
				sn_s[i+1] <= sn_s[i];
				sq_s[i+1] <= sq;
				sr_s[i+1] <= sr;
				hd_s[i+1] <= hd_s[i];
				sd_s[i+1] <= sd_s[i];
				l_s[i+1] <= l_s[i];
				g_s[i+1] <= g_s[i];
			end
		end
	end

	assign out_valid = v_s[ST];
	assign hue = g_s[ST] ? '0 : HUE_BITS'(hq_s[ST]);
	assign sat = g_s[ST] ? '0 : CB'(sq_s[ST]);
	assign lsum = l_s[ST];
	assign gr = g_s[ST];
endmodule

### sv/rgb_to_hsl_converter_core.sv
// RGB to HSL converter, top level. An accepted item passes the front output
// register, the queue, the divider input register and one register per divider
// stage before m_tvalid rises. Throughput is one item per cycle while m_tready
// stays high, as every part is pipelined.
// Reset clears the valid flags, queue pointers and count; data is not reset.
// Depends on rgbhsl_pkg, rgbhsl_front, rgbhsl_queue and rgbhsl_back.
module rgb_to_hsl_converter_core #(
	parameter int unsigned CHANNEL_BITS = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// red, green, blue
	input  logic [((3*CHANNEL_BITS+7)/8)*8-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// hue_sixteenths, saturation_level, lightness_sum
	output logic [((2*CHANNEL_BITS+14+7)/8)*8-1:0] m_tdata,
	// is_gray
	output logic m_tuser
);
	import rgbhsl_pkg::*;
	localparam int unsigned CB = CHANNEL_BITS;
	localparam int unsigned QW = (CB + 3) + CB + (CB + 1) + (CB + 1) + 1;
	localparam int unsigned OW = ((2 * CB + 14 + 7) / 8) * 8;

	logic fv, fr, qv, qr;
	logic [QW-1:0] fd, qd;
	logic [CB+2:0] num;
	logic [CB-1:0] span, sat;
	logic [CB:0] den, sum, lsum;
	logic gray;
	logic [HUE_BITS-1:0] hue;

	rgbhsl_front #(.CB(CB)) u_front (
		.clk, .arst_n, .in_valid(s_tvalid), .in_ready(s_tready),
		.red(s_tdata[CB-1:0]), .green(s_tdata[2*CB-1:CB]), .blue(s_tdata[3*CB-1:2*CB]),
		.out_valid(fv), .out_ready(fr), .num, .span, .den, .sum, .gray
	);

	assign fd = {num, span, den, sum, gray};

	rgbhsl_queue #(.W(QW)) u_queue (
		.clk, .arst_n, .in_valid(fv), .in_ready(fr), .in_data(fd),
		.out_valid(qv), .out_ready(qr), .out_data(qd)
	);

	rgbhsl_back #(.CB(CB)) u_back (
		.clk, .arst_n, .in_valid(qv), .in_ready(qr),
		.num(qd[QW-1 -: CB+3]), .span(qd[2*CB+3 +: CB]), .den(qd[CB+2 +: CB+1]),
		.sum(qd[1 +: CB+1]), .gray(qd[0]),
		.out_valid(m_tvalid), .out_ready(m_tready), .hue, .sat, .lsum, .gr(m_tuser)
	);

	assign m_tdata = OW'({lsum, sat, hue});

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[HUE_BITS+CB-1:0] == '0)
		else $error("gray item with nonzero hue or saturation");
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> hue < HUE_BITS'(6 * SIXTEENTHS_PER_SECTOR))
		else $error("hue out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");
endmodule

### tb/rgb_to_hsl_converter_core_test.sv
// Self-checking bench for the RGB to HSL converter core: drives pixels on the
// input stream, predicts hue, saturation, lightness and the gray flag per pixel
// and compares them with the output stream. Depends on rgb_to_hsl_converter_core.
module rgb_to_hsl_converter_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CB = 8;
	localparam int unsigned FS = (1 << CB) - 1;
	localparam int unsigned SW = ((3*CB+7)/8)*8;
	localparam int unsigned MW = ((2*CB+14+7)/8)*8;
	localparam int LIMIT = 20000;

	typedef struct packed {
		logic [12:0] hue;
		logic [CB-1:0] sat;
		logic [CB:0] light;
		logic gray;
	} hsl_t;

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [SW-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [MW-1:0] m_tdata;
	logic m_tuser;

	logic [SW-1:0] pending_pixels[$];
	hsl_t expected_colours[$];
	int errors = 0;
	int sent = 0;
	int received = 0;
	int total = 0;
	int grays = 0;
	int quiet = 0;
	int send_gap = 0;
	int recv_gap = 0;
	bit calm = 0;
	bit hold = 0;
	bit done = 0;

	rgb_to_hsl_converter_core #(.CHANNEL_BITS(CB)) dut (.*);

	always #2 clk = ~clk;

	function automatic hsl_t convert_pixel(logic [SW-1:0] px);
		int unsigned r, g, b, hi, lo, span, sum, num, den;
		hsl_t c;
		r = px[CB-1:0];
		g = px[2*CB-1:CB];
		b = px[3*CB-1:2*CB];
		hi = r;
		if (g > hi) hi = g;
		if (b > hi) hi = b;
		lo = r;
		if (g < lo) lo = g;
		if (b < lo) lo = b;
		span = hi - lo;
		sum = hi + lo;
		c = '0;
		c.light = sum;
		c.gray = (span == 0);
		if (span != 0) begin
			if (r >= g && r >= b) begin
				num = (g >= b) ? g - b : 6*span - (b - g);
			end else if (g >= r && g >= b) begin
				num = 2*span + b - r;
			end else begin
				num = 4*span + r - g;
			end
			c.hue = (960 * num) / span;
			den = (sum <= FS) ? sum : 2*FS - sum;
			c.sat = (den != 0) ? (span * FS) / den : 0;
		end
		return c;
	endfunction

	function automatic logic [SW-1:0] pack_pixel(int r, int g, int b);
		logic [SW-1:0] px;
		px = '0;
		px[CB-1:0] = r;
		px[2*CB-1:CB] = g;
		px[3*CB-1:2*CB] = b;
		return px;
	endfunction

	always @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			expected_colours.push_back(convert_pixel(s_tdata));
			sent++;
		end
		if (!arst_n) begin
			s_tvalid <= 0;
		end else if (!(s_tvalid && !s_tready)) begin
			if (send_gap > 0) begin
				send_gap--;
				s_tvalid <= 0;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				send_gap = $urandom_range(1, 15);
				s_tvalid <= 0;
			end else if (!hold && pending_pixels.size() > 0) begin
				s_tvalid <= 1;
				s_tdata <= pending_pixels.pop_front();
			end else begin
				s_tvalid <= 0;
			end
		end
	end

	always @(posedge clk) begin
		hsl_t got, want;
		if (m_tvalid && m_tready) begin
			got = {m_tdata[12:0], m_tdata[13+CB-1:13], m_tdata[13+2*CB:13+CB], m_tuser};
			received++;
			if (got.gray) grays++;
			if (expected_colours.size() == 0) begin
				$error("unexpected result %h", got);
				errors++;
			end else begin
				want = expected_colours.pop_front();
				if (got.hue !== want.hue) begin
					$error("hue_sixteenths expected %0d got %0d", want.hue, got.hue);
					errors++;
				end
				if (got.sat !== want.sat) begin
					$error("saturation_level expected %0d got %0d", want.sat, got.sat);
					errors++;
				end
				if (got.light !== want.light) begin
					$error("lightness_sum expected %0d got %0d", want.light, got.light);
					errors++;
				end
				if (got.gray !== want.gray) begin
					$error("is_gray expected %0d got %0d", want.gray, got.gray);
					errors++;
				end
			end
		end
		if (!arst_n) begin
			m_tready <= 0;
		end else if (recv_gap > 0) begin
			recv_gap--;
			m_tready <= 0;
		end else if (!calm && $urandom_range(0, 9) == 0) begin
			recv_gap = $urandom_range(1, 15);
			m_tready <= 0;
		end else begin
			m_tready <= 1;
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n || done) begin
			quiet = 0;
		end else if (++quiet >= LIMIT) begin
			$display("timeout with %0d results outstanding", expected_colours.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		int r, g, b;
		// Extremes, every winning channel, ties and gray pixels.
		pending_pixels.push_back(pack_pixel(0, 0, 0));
		pending_pixels.push_back(pack_pixel(255, 255, 255));
		pending_pixels.push_back(pack_pixel(128, 128, 128));
		pending_pixels.push_back(pack_pixel(255, 0, 0));
		pending_pixels.push_back(pack_pixel(0, 255, 0));
		pending_pixels.push_back(pack_pixel(0, 0, 255));
		pending_pixels.push_back(pack_pixel(255, 255, 0));
		pending_pixels.push_back(pack_pixel(0, 255, 255));
		pending_pixels.push_back(pack_pixel(255, 0, 255));
		pending_pixels.push_back(pack_pixel(255, 0, 1));
		pending_pixels.push_back(pack_pixel(255, 1, 0));
		pending_pixels.push_back(pack_pixel(1, 255, 0));
		pending_pixels.push_back(pack_pixel(0, 1, 255));
		pending_pixels.push_back(pack_pixel(1, 0, 255));
		pending_pixels.push_back(pack_pixel(0, 255, 1));
		pending_pixels.push_back(pack_pixel(1, 0, 0));
		pending_pixels.push_back(pack_pixel(255, 254, 254));
		pending_pixels.push_back(pack_pixel(127, 128, 128));
		pending_pixels.push_back(pack_pixel(128, 127, 127));
		pending_pixels.push_back(pack_pixel(170, 85, 0));
		pending_pixels.push_back(pack_pixel(0, 85, 170));
		total = pending_pixels.size();
		repeat (12) @(posedge clk);
		arst_n <= 1;
		wait (pending_pixels.size() == 0);
		hold = 1;
		wait (received == total);
		hold = 0;
		for (int i = 0; i < 750; i++) begin
			r = $urandom_range(0, 255);
			g = $urandom_range(0, 255);
			b = $urandom_range(0, 255);
			case ($urandom_range(0, 7))
				0: begin g = r; b = r; end
				1: g = r;
				2: b = g;
				3: begin r = $urandom_range(0, 1) * 255; end
				default: ;
			endcase
			pending_pixels.push_back(pack_pixel(r, g, b));
			total++;
			if (i == 600) begin
				wait (pending_pixels.size() == 0);
				calm = 1;
			end
		end
		wait (received == total);
		done = 1;
		repeat (50) @(posedge clk);
		$display("Sent %0d pixels and checked %0d results, %0d of them gray,", sent, received,
			grays);
		$display("with random stalls on both streams and a drain pause mid-run.");
		if (errors == 0 && expected_colours.size() == 0 && received == total) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end
endmodule

### sim.f
sv/rgbhsl_pkg.sv
sv/rgbhsl_front.sv
sv/rgbhsl_queue.sv
sv/rgbhsl_back.sv
sv/rgb_to_hsl_converter_core.sv
tb/rgb_to_hsl_converter_core_test.sv
